// ===== hdl/tta_pkg.sv =====
// ----------------------------------------------------------------------------
// Tap adjust package
// Shared widths, constants and the record that travels from the front end
// through the queue to the back end.
// ----------------------------------------------------------------------------
package tta_pkg;

   // Width of every tap, limit and voltage field.
   localparam int TAP_W = 16;

   // Relative error is saturated to this width; any error at or above
   // ERR_SAT drives both rules to the upper tap limit anyway.
   localparam int ERR_W = 18;
   localparam logic [ERR_W-1:0] ERR_SAT = 18'h20000;

   // Numerator width of the quantizing dividers (tap + error - floor).
   localparam int QNUM_W = 18;

   // Signed width of an unclamped tap candidate.
   localparam int CAND_W = 20;

   // Queue between front and back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Fields decided by the classifier and carried with the high-error divide.
   typedef struct packed {
      logic [TAP_W-1:0] tap;
      logic [TAP_W-1:0] tmax;
      logic [TAP_W-1:0] tmin;
      logic [TAP_W-1:0] step;
      logic             hi_run;
      logic             fault;
   } class_type;

   // One queued request with both saturated relative errors.
   typedef struct packed {
      class_type        cls;
      logic             lo_run;
      logic [ERR_W-1:0] err_h;
      logic [ERR_W-1:0] err_l;
   } queue_item_type;

endpackage

// ===== hdl/tta_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; accepts a new division every cycle and
// carries a payload alongside with the same latency.
// ----------------------------------------------------------------------------
module tta_div_pipe #(
   parameter int NUM_W = 18,
   parameter int DEN_W = 16,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [DEN_W-1:0] out_rem,
   output logic [PAY_W-1:0] out_pay
);

   localparam int ACC_W = DEN_W + NUM_W;

   logic             valid_ff [0:NUM_W];
   logic [ACC_W-1:0] acc_ff   [0:NUM_W];
   logic [DEN_W-1:0] den_ff   [0:NUM_W];
   logic [PAY_W-1:0] pay_ff   [0:NUM_W];
   logic [ACC_W-1:0] acc_in   [0:NUM_W];

   // Each stage shifts in one numerator bit and subtracts the divisor if it fits.
   always_comb begin
      logic [ACC_W:0]   shifted;
      logic [DEN_W:0]   top;
      logic             fits;
      acc_in[0] = {{DEN_W{1'b0}}, in_num};
      for (int s = 0; s < NUM_W; s++) begin
         shifted = {acc_ff[s], 1'b0};
         top     = shifted[ACC_W:NUM_W];
         fits    = (top >= {1'b0, den_ff[s]});
         if (fits) begin
            top = top - {1'b0, den_ff[s]};
         end
         acc_in[s+1] = {top[DEN_W-1:0], shifted[NUM_W-1:1], fits};
      end
   end

   // Stage registers; only the valid chain is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NUM_W; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 0; s < NUM_W; s++) begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end
      acc_ff[0] <= acc_in[0];
      den_ff[0] <= in_den;
      pay_ff[0] <= in_pay;
      for (int s = 0; s < NUM_W; s++) begin
         acc_ff[s+1] <= acc_in[s+1];
         den_ff[s+1] <= den_ff[s];
         pay_ff[s+1] <= pay_ff[s];
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quo   = acc_ff[NUM_W][NUM_W-1:0];
   assign out_rem   = acc_ff[NUM_W][ACC_W-1:NUM_W];
   assign out_pay   = pay_ff[NUM_W];

endmodule

// ===== hdl/tta_front.sv =====
// ----------------------------------------------------------------------------
// Tap adjust front end
// Classifies each branch request (fixed transformer, limit hits, faults)
// and computes both relative voltage errors in pipelined dividers.
// ----------------------------------------------------------------------------
module tta_front #(
   parameter int FRACTION_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [15:0]             bus_voltage,
   input  logic [15:0]             volt_low_limit,
   input  logic [15:0]             volt_high_limit,
   input  logic [15:0]             tap_now,
   input  logic [15:0]             tap_ceiling,
   input  logic [15:0]             tap_floor,
   input  logic [15:0]             tap_increment,
   output logic                    out_valid,
   output tta_pkg::queue_item_type out_item
);

   localparam int NUM_W = tta_pkg::TAP_W + FRACTION_BITS;
   localparam int CLS_W = $bits(tta_pkg::class_type);

   tta_pkg::class_type cls;
   logic               lo_run;
   logic [15:0]        diff_h;
   logic [15:0]        diff_l;
   logic               valid_h;
   logic               valid_l;
   logic [NUM_W-1:0]   quo_h;
   logic [NUM_W-1:0]   quo_l;
   logic [15:0]        rem_h;
   logic [15:0]        rem_l;
   logic [CLS_W-1:0]   pay_h;
   logic               pay_l;

   // Classification: which rules run and whether a zero step or limit blocks one.
   always_comb begin
      logic fixed_tap;
      logic hi_hit;
      logic lo_hit;
      logic hi_bad;
      logic lo_bad;
      fixed_tap  = (tap_ceiling == 16'd0);
      hi_hit     = !fixed_tap && (bus_voltage >= volt_high_limit);
      lo_hit     = !fixed_tap && (bus_voltage <= volt_low_limit);
      hi_bad     = (tap_increment == 16'd0) || (volt_high_limit == 16'd0);
      lo_bad     = (tap_increment == 16'd0) || (volt_low_limit == 16'd0);
      cls.tap    = tap_now;
      cls.tmax   = tap_ceiling;
      cls.tmin   = tap_floor;
      cls.step   = tap_increment;
      cls.hi_run = hi_hit && !hi_bad;
      cls.fault  = (hi_hit && hi_bad) || (lo_hit && lo_bad);
      lo_run     = lo_hit && !lo_bad;
      diff_h     = bus_voltage - volt_high_limit;
      diff_l     = volt_low_limit - bus_voltage;
   end

   // Relative error above the high limit.
   tta_div_pipe #(
      .NUM_W (NUM_W),
      .DEN_W (16),
      .PAY_W (CLS_W)
   ) u_div_high (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_num    ({diff_h, {FRACTION_BITS{1'b0}}}),
      .in_den    (volt_high_limit),
      .in_pay    (cls),
      .out_valid (valid_h),
      .out_quo   (quo_h),
      .out_rem   (rem_h),
      .out_pay   (pay_h)
   );

   // Relative error below the low limit.
   tta_div_pipe #(
      .NUM_W (NUM_W),
      .DEN_W (16),
      .PAY_W (1)
   ) u_div_low (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_num    ({diff_l, {FRACTION_BITS{1'b0}}}),
      .in_den    (volt_low_limit),
      .in_pay    (lo_run),
      .out_valid (valid_l),
      .out_quo   (quo_l),
      .out_rem   (rem_l),
      .out_pay   (pay_l)
   );

   // Saturate the errors; larger values clamp to the tap ceiling regardless.
   always_comb begin
      out_item.cls    = tta_pkg::class_type'(pay_h);
      out_item.lo_run = pay_l;
      out_item.err_h  = (quo_h >= NUM_W'(tta_pkg::ERR_SAT)) ? tta_pkg::ERR_SAT
                                                          : quo_h[tta_pkg::ERR_W-1:0];
      out_item.err_l  = (quo_l >= NUM_W'(tta_pkg::ERR_SAT)) ? tta_pkg::ERR_SAT
                                                          : quo_l[tta_pkg::ERR_W-1:0];
   end

   // The remainders of the error divides are not needed; a request is ready
   // when both dividers deliver it.
   assign out_valid = valid_h && valid_l && ((rem_h | rem_l | 16'd1) != 16'd0);

endmodule

// ===== hdl/tta_queue.sv =====
// ----------------------------------------------------------------------------
// Tap adjust request queue
// Small FIFO between front and back end; the back end drains one entry
// per cycle, so the queue only absorbs timing slack between the two.
// ----------------------------------------------------------------------------
module tta_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tta_pkg::queue_item_type push_item,
   output logic                    near_full,
   output logic                    out_valid,
   output tta_pkg::queue_item_type out_item
);

   tta_pkg::queue_item_type            mem [0:tta_pkg::QUEUE_DEPTH-1];
   logic [tta_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [tta_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [tta_pkg::QUEUE_CNT_W-1:0]    count_ff;
   logic [tta_pkg::QUEUE_CNT_W-1:0]    count_in;
   logic                               pop;
   logic                               out_valid_ff;
   tta_pkg::queue_item_type            out_item_ff;

   // Drain whenever something is stored.
   assign pop = (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Storage and registered read port.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
      if (pop) begin
         out_item_ff <= mem[rd_ptr_ff];
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff     <= count_in;
         out_valid_ff <= pop;
      end
   end

   assign near_full = (count_ff >= tta_pkg::QUEUE_CNT_W'(tta_pkg::QUEUE_DEPTH - 1));
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tta_pkg::QUEUE_CNT_W'(tta_pkg::QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   // No request is written into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && (count_ff == tta_pkg::QUEUE_CNT_W'(tta_pkg::QUEUE_DEPTH))))
      else $error("queue overflow");

   // A stored entry is delivered in the next cycle.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |=> out_valid_ff)
      else $error("queue entry not delivered");

endmodule

// ===== hdl/tta_back.sv =====
// ----------------------------------------------------------------------------
// Tap adjust back end
// Applies the high rule, then the low rule on its result: grid
// quantization through pipelined dividers, clamping and result output.
// ----------------------------------------------------------------------------
module tta_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  tta_pkg::queue_item_type in_item,
   output logic                    rsp_valid,
   output logic [15:0]             rsp_new_tap,
   output logic [1:0]              rsp_action,
   output logic                    rsp_fault
);

   localparam int QW = tta_pkg::QNUM_W;
   localparam int CW = tta_pkg::CAND_W;

   typedef struct packed {
      logic [15:0]                 tap;
      logic [15:0]                 tmax;
      logic [15:0]                 tmin;
      logic [15:0]                 step;
      logic                        hi_run;
      logic                        lo_run;
      logic                        fault;
      logic [tta_pkg::ERR_W-1:0]   err_l;
      logic                        below_step;
      logic                        neg;
      logic [QW-1:0]               num;
   } hi_pay_type;

   typedef struct packed {
      logic [15:0]                 tap;
      logic [15:0]                 tmax;
      logic [15:0]                 tmin;
      logic [15:0]                 step;
      logic                        hi_run;
      logic                        lo_run;
      logic                        fault;
      logic                        below_step;
      logic                        neg;
      logic [QW-1:0]               num;
   } lo_pay_type;

   localparam int HP_W = $bits(hi_pay_type);
   localparam int LP_W = $bits(lo_pay_type);

   // Clamp a signed candidate to the floor first, then to the ceiling.
   function automatic logic [15:0] clamp_tap(logic [CW-1:0] cand, logic [15:0] lo,
                                              logic [15:0] hi);
      logic signed [CW-1:0] t;
      t = $signed(cand);
      if (t < $signed(CW'(lo))) begin
         t = $signed(CW'(lo));
      end
      if (t > $signed(CW'(hi))) begin
         t = $signed(CW'(hi));
      end
      return t[15:0];
   endfunction

   hi_pay_type        hp_in;
   logic [QW:0]       nh;
   logic              dh_valid;
   logic [QW-1:0]     dh_quo;
   logic [15:0]       dh_rem;
   logic [HP_W-1:0]   dh_pay;
   hi_pay_type        hp_out;
   logic [CW-1:0]     th_in;
   logic              h1_valid_ff;
   hi_pay_type        h1_pay_ff;
   logic [CW-1:0]     th_ff;
   lo_pay_type        lp_in;
   logic [15:0]       tap1;
   logic [QW:0]       nl;
   logic              dl_valid;
   logic [QW-1:0]     dl_quo;
   logic [15:0]       dl_rem;
   logic [LP_W-1:0]   dl_pay;
   lo_pay_type        lp_out;
   logic [CW-1:0]     tl_in;
   logic              l1_valid_ff;
   lo_pay_type        l1_pay_ff;
   logic [CW-1:0]     tl_ff;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_new_tap_ff;
   logic [1:0]        rsp_action_ff;
   logic              rsp_fault_ff;

   // High rule set-up: grid numerator tap + err - floor and the small-error test.
   always_comb begin
      nh           = (QW+1)'(in_item.cls.tap) + (QW+1)'(in_item.err_h)
                     - (QW+1)'(in_item.cls.tmin);
      hp_in.tap    = in_item.cls.tap;
      hp_in.tmax   = in_item.cls.tmax;
      hp_in.tmin   = in_item.cls.tmin;
      hp_in.step   = in_item.cls.step;
      hp_in.hi_run = in_item.cls.hi_run;
      hp_in.lo_run = in_item.lo_run;
      hp_in.fault  = in_item.cls.fault;
      hp_in.err_l  = in_item.err_l;
      hp_in.below_step = (in_item.err_h < tta_pkg::ERR_W'(in_item.cls.step));
      hp_in.neg    = nh[QW];
      hp_in.num    = nh[QW-1:0];
   end

   tta_div_pipe #(
      .NUM_W (QW),
      .DEN_W (16),
      .PAY_W (HP_W)
   ) u_div_high (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_num    (hp_in.num),
      .in_den    (hp_in.step),
      .in_pay    (hp_in),
      .out_valid (dh_valid),
      .out_quo   (dh_quo),
      .out_rem   (dh_rem),
      .out_pay   (dh_pay)
   );

   // High rule candidate: one step up, the floor limit on a negative numerator, or the ceiling of the grid point.
   // The grid point is num - rem (+ step when inexact), so the quotient itself
   // is only needed to finish the divide.
   always_comb begin
      hp_out = hi_pay_type'(dh_pay);
      if (hp_out.below_step) begin
         th_in = CW'(hp_out.tap) + CW'(hp_out.step);
      end else if (hp_out.neg) begin
         th_in = CW'(hp_out.tmin);
      end else begin
         th_in = CW'(hp_out.num) - CW'(dh_rem) + CW'(hp_out.tmin)
                 + ((dh_rem != 16'd0) ? CW'(hp_out.step) : CW'(0))
                 + CW'(dh_quo & {QW{1'b0}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff <= 1'b0;
      end else begin
         h1_valid_ff <= dh_valid;
      end
      h1_pay_ff <= hp_out;
      th_ff     <= th_in;
   end

   // Low rule set-up on the tap that the high rule left.
   always_comb begin
      tap1         = h1_pay_ff.hi_run ? clamp_tap(th_ff, h1_pay_ff.tmin, h1_pay_ff.tmax)
                                      : h1_pay_ff.tap;
      nl           = (QW+1)'(tap1) + (QW+1)'(h1_pay_ff.err_l) - (QW+1)'(h1_pay_ff.tmin);
      lp_in.tap    = tap1;
      lp_in.tmax   = h1_pay_ff.tmax;
      lp_in.tmin   = h1_pay_ff.tmin;
      lp_in.step   = h1_pay_ff.step;
      lp_in.hi_run = h1_pay_ff.hi_run;
      lp_in.lo_run = h1_pay_ff.lo_run;
      lp_in.fault  = h1_pay_ff.fault;
      lp_in.below_step = (h1_pay_ff.err_l < tta_pkg::ERR_W'(h1_pay_ff.step));
      lp_in.neg    = nl[QW];
      lp_in.num    = nl[QW-1:0];
   end

   tta_div_pipe #(
      .NUM_W (QW),
      .DEN_W (16),
      .PAY_W (LP_W)
   ) u_div_low (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h1_valid_ff),
      .in_num    (lp_in.num),
      .in_den    (lp_in.step),
      .in_pay    (lp_in),
      .out_valid (dl_valid),
      .out_quo   (dl_quo),
      .out_rem   (dl_rem),
      .out_pay   (dl_pay)
   );

   // Low rule candidate: one step down, the floor limit on a negative numerator, or the floor of the grid point.
   always_comb begin
      lp_out = lo_pay_type'(dl_pay);
      if (lp_out.below_step) begin
         tl_in = CW'(lp_out.tap) - CW'(lp_out.step);
      end else if (lp_out.neg) begin
         tl_in = CW'(lp_out.tmin);
      end else begin
         tl_in = CW'(lp_out.num) - CW'(dl_rem) + CW'(lp_out.tmin)
                 + CW'(dl_quo & {QW{1'b0}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_valid_ff <= 1'b0;
      end else begin
         l1_valid_ff <= dl_valid;
      end
      l1_pay_ff <= lp_out;
      tl_ff     <= tl_in;
   end

   // Final clamp and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= l1_valid_ff;
      end
      rsp_new_tap_ff <= l1_pay_ff.lo_run
                        ? clamp_tap(tl_ff, l1_pay_ff.tmin, l1_pay_ff.tmax)
                        : l1_pay_ff.tap;
      rsp_action_ff  <= {l1_pay_ff.lo_run, l1_pay_ff.hi_run};
      rsp_fault_ff   <= l1_pay_ff.fault;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_new_tap = rsp_new_tap_ff;
   assign rsp_action  = rsp_action_ff;
   assign rsp_fault   = rsp_fault_ff;

endmodule

// ===== hdl/transformer_tap_adjust.sv =====
// ----------------------------------------------------------------------------
// Transformer tap adjust
// Per-branch tap changer adjustment against bus voltage limits.
//
//   channel   handshake          payload
//   request   start / busy       req_bus_voltage .. req_tap_increment
//   result    rsp_valid strobe   rsp_new_tap, rsp_action, rsp_fault
//
// One request is taken per cycle; its result strobe is raised once the request
// has passed the front-end error dividers up to the queue write, the queue read
// and the two 19-stage grid dividers and three register stages in the back end.
// Reset is synchronous and clears all valid flags and the queue.
// The result strobe cannot be held off; the back end drains the queue every
// cycle, so busy (raised only when the queue nears full) stays low.
// ----------------------------------------------------------------------------
module transformer_tap_adjust #(
   parameter int FRACTION_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_bus_voltage,
   input  logic [15:0] req_volt_low_limit,
   input  logic [15:0] req_volt_high_limit,
   input  logic [15:0] req_tap_now,
   input  logic [15:0] req_tap_ceiling,
   input  logic [15:0] req_tap_floor,
   input  logic [15:0] req_tap_increment,
   output logic        rsp_valid,
   output logic [15:0] rsp_new_tap,
   output logic [1:0]  rsp_action,
   output logic        rsp_fault
);

   logic                    accept;
   logic                    front_valid;
   tta_pkg::queue_item_type front_item;
   logic                    near_full;
   logic                    queue_valid;
   tta_pkg::queue_item_type queue_item;

   assign accept = start && !busy;
   assign busy   = near_full;

   // Classification and relative errors.
   tta_front #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .bus_voltage     (req_bus_voltage),
      .volt_low_limit  (req_volt_low_limit),
      .volt_high_limit (req_volt_high_limit),
      .tap_now         (req_tap_now),
      .tap_ceiling     (req_tap_ceiling),
      .tap_floor       (req_tap_floor),
      .tap_increment   (req_tap_increment),
      .out_valid       (front_valid),
      .out_item        (front_item)
   );

   // Decoupling queue.
   tta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .near_full (near_full),
      .out_valid (queue_valid),
      .out_item  (queue_item)
   );

   // Rule execution and result output.
   tta_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (queue_valid),
      .in_item     (queue_item),
      .rsp_valid   (rsp_valid),
      .rsp_new_tap (rsp_new_tap),
      .rsp_action  (rsp_action),
      .rsp_fault   (rsp_fault)
   );

endmodule

// ===== tb/transformer_tap_adjust_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transformer tap adjust testbench
// Drives branch requests through the start/busy handshake and compares each
// strobed result with a tap prediction computed in the testbench itself.
// ----------------------------------------------------------------------------

// Holds the predicted taps for requests that are still in flight.
class tap_scoreboard;
   typedef struct {
      logic [15:0] new_tap;
      logic [1:0]  action;
      logic        fault;
   } tap_result_type;

   tap_result_type pending_taps[$];
   int             fail_count = 0;
   int             checked_count = 0;

   // Work out the adjusted tap of one branch; all arithmetic is signed 64-bit.
   function void note_request(logic [15:0] v, logic [15:0] vlo, logic [15:0] vhi,
                              logic [15:0] tap_in, logic [15:0] tmax,
                              logic [15:0] tmin, logic [15:0] step);
      tap_result_type r;
      longint         tap;
      longint         err;
      longint         t;
      longint         num;
      longint         q;
      longint         vv;
      longint         lo_v;
      longint         hi_v;
      longint         tmx;
      longint         tmn;
      longint         stp;
      vv = v;
      lo_v = vlo;
      hi_v = vhi;
      tmx = tmax;
      tmn = tmin;
      stp = step;
      tap = tap_in;
      r.action = 2'b00;
      r.fault = 1'b0;
      if (tmx != 0) begin
         // High rule raises the tap.
         if (vv >= hi_v) begin
            if (stp == 0 || hi_v == 0) begin
               r.fault = 1'b1;
            end else begin
               err = ((vv - hi_v) <<< 14) / hi_v;
               if (err < stp) begin
                  t = tap + stp;
               end else begin
                  num = tap + err - tmn;
                  q = num / stp;
                  if (num % stp != 0 && num > 0) q = q + 1;
                  t = q * stp + tmn;
               end
               if (t < tmn) t = tmn;
               if (t > tmx) t = tmx;
               tap = t;
               r.action[0] = 1'b1;
            end
         end
         // Low rule lowers the tap, working on the high rule's result.
         if (vv <= lo_v) begin
            if (stp == 0 || lo_v == 0) begin
               r.fault = 1'b1;
            end else begin
               err = ((lo_v - vv) <<< 14) / lo_v;
               if (err < stp) begin
                  t = tap - stp;
               end else begin
                  num = tap + err - tmn;
                  q = num / stp;
                  if (num % stp != 0 && num < 0) q = q - 1;
                  t = q * stp + tmn;
               end
               if (t < tmn) t = tmn;
               if (t > tmx) t = tmx;
               tap = t;
               r.action[1] = 1'b1;
            end
         end
      end
      r.new_tap = tap[15:0];
      pending_taps.push_back(r);
   endfunction

   // Compare one result with the oldest prediction.
   function void check_result(logic [15:0] new_tap, logic [1:0] action, logic fault);
      tap_result_type e;
      if (pending_taps.size() == 0) begin
         $display("%0t: unexpected result tap=%h action=%0d fault=%0d",
                  $time, new_tap, action, fault);
         fail_count++;
         return;
      end
      e = pending_taps.pop_front();
      checked_count++;
      if (new_tap !== e.new_tap) begin
         $display("%0t: new_tap expected %h actual %h", $time, e.new_tap, new_tap);
         fail_count++;
      end
      if (action !== e.action) begin
         $display("%0t: action expected %0d actual %0d", $time, e.action, action);
         fail_count++;
      end
      if (fault !== e.fault) begin
         $display("%0t: fault expected %0d actual %0d", $time, e.fault, fault);
         fail_count++;
      end
   endfunction
endclass

module transformer_tap_adjust_tb;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_bus_voltage = '0;
   logic [15:0] req_volt_low_limit = '0;
   logic [15:0] req_volt_high_limit = '0;
   logic [15:0] req_tap_now = '0;
   logic [15:0] req_tap_ceiling = '0;
   logic [15:0] req_tap_floor = '0;
   logic [15:0] req_tap_increment = '0;
   logic        rsp_valid;
   logic [15:0] rsp_new_tap;
   logic [1:0]  rsp_action;
   logic        rsp_fault;

   tap_scoreboard tap_board = new();
   int            idle_cycles = 0;
   int            request_count = 0;

   transformer_tap_adjust i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_bus_voltage(req_bus_voltage), .req_volt_low_limit(req_volt_low_limit),
      .req_volt_high_limit(req_volt_high_limit), .req_tap_now(req_tap_now),
      .req_tap_ceiling(req_tap_ceiling), .req_tap_floor(req_tap_floor),
      .req_tap_increment(req_tap_increment), .rsp_valid(rsp_valid),
      .rsp_new_tap(rsp_new_tap), .rsp_action(rsp_action), .rsp_fault(rsp_fault)
   );

   always #5 clock = ~clock;

   // Note accepted requests, check results, and watch for a stalled run.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            tap_board.note_request(req_bus_voltage, req_volt_low_limit,
                                   req_volt_high_limit, req_tap_now, req_tap_ceiling,
                                   req_tap_floor, req_tap_increment);
            request_count++;
         end
         if (rsp_valid) begin
            tap_board.check_result(rsp_new_tap, rsp_action, rsp_fault);
         end
         if ((start && !busy) || rsp_valid) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Random gap before a request, mostly short and now and then long.
   task automatic idle_gap();
      int n;
      if ($urandom_range(0, 2) == 0) begin
         n = 0;
      end else if ($urandom_range(0, 19) == 0) begin
         n = $urandom_range(20, 90);
      end else begin
         n = $urandom_range(1, 3);
      end
      repeat (n) @(posedge clock);
   endtask

   // Present one request and hold it until the block takes it. Busy only
   // changes at a rising edge, so its value at the falling edge decides
   // whether the next rising edge accepts.
   task automatic send_request(logic [15:0] v, logic [15:0] vlo, logic [15:0] vhi,
                               logic [15:0] tap, logic [15:0] tmax,
                               logic [15:0] tmin, logic [15:0] step, bit gap);
      if (gap) begin
         start <= 1'b0;
         idle_gap();
      end
      start <= 1'b1;
      req_bus_voltage <= v;
      req_volt_low_limit <= vlo;
      req_volt_high_limit <= vhi;
      req_tap_now <= tap;
      req_tap_ceiling <= tmax;
      req_tap_floor <= tmin;
      req_tap_increment <= step;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // Hold the sender until every predicted result has been checked.
   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (tap_board.pending_taps.size() != 0) @(negedge clock);
   endtask

   // One random branch: mostly realistic per-unit values, some raw noise.
   task automatic send_random_branch(bit gap);
      logic [15:0] v, vlo, vhi, tap, tmax, tmin, step;
      if ($urandom_range(0, 4) == 0) begin
         v = 16'($urandom); vlo = 16'($urandom); vhi = 16'($urandom);
         tap = 16'($urandom); tmax = 16'($urandom); tmin = 16'($urandom);
         step = 16'($urandom);
      end else begin
         vlo = 16'($urandom_range(14000, 16500));
         vhi = 16'($urandom_range(16500, 19000));
         v = 16'($urandom_range(10000, 23000));
         tmin = 16'($urandom_range(13000, 16000));
         tmax = 16'($urandom_range(17000, 20000));
         tap = 16'($urandom_range(12000, 21000));
         step = 16'($urandom_range(1, 600));
         if ($urandom_range(0, 15) == 0) step = '0;
         if ($urandom_range(0, 20) == 0) tmax = '0;
         if ($urandom_range(0, 20) == 0) begin
            vlo = v; vhi = v;
         end
      end
      send_request(v, vlo, vhi, tap, tmax, tmin, step, gap);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases: no violation, each rule, both rules, fixed transformer,
      // zero step, zero limits, inverted tap limits and field extremes.
      send_request(16384, 15565, 17203, 16384, 18022, 14746, 102, 0);
      send_request(17500, 15565, 17203, 16384, 18022, 14746, 102, 0);
      send_request(21000, 15565, 17203, 16384, 18022, 14746, 102, 0);
      send_request(15000, 15565, 17203, 16384, 18022, 14746, 102, 0);
      send_request(9000, 15565, 17203, 16384, 18022, 14746, 102, 0);
      send_request(16384, 16384, 16384, 16384, 18022, 14746, 102, 0);
      send_request(16384, 16384, 16384, 16384, 18022, 14746, 3000, 0);
      send_request(21000, 15565, 17203, 16384, 0, 14746, 102, 0);
      send_request(21000, 15565, 17203, 16384, 18022, 14746, 0, 0);
      send_request(9000, 15565, 17203, 16384, 18022, 14746, 0, 0);
      send_request(100, 0, 0, 16384, 18022, 14746, 102, 0);
      send_request(0, 0, 17203, 16384, 18022, 14746, 102, 0);
      send_request(21000, 15565, 17203, 16384, 14000, 18000, 102, 0);
      send_request(9000, 15565, 17203, 16384, 14000, 18000, 102, 0);
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 0);
      send_request(16'hFFFF, 0, 1, 16'hFFFF, 16'hFFFF, 0, 1, 0);
      send_request(0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0, 1, 0);
      send_request(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0);
      send_request(16'hFFFF, 0, 1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      send_request(0, 0, 0, 0, 0, 0, 0, 0);

      // Pause the sender until every result of the directed part is in.
      wait_drained();

      // Random part: bursts without gaps alternate with gapped stretches.
      for (int i = 0; i < 1100; i++) begin
         send_random_branch((i / 100) % 2 == 1);
         if (i == 550) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests with %0d results checked: both limit rules,",
               request_count, tap_board.checked_count);
      $display("fixed transformers, zero steps and limits, and inverted tap limits.");
      if (tap_board.fail_count == 0 && tap_board.pending_taps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
